FILE: src/thermistor_humidity_linearizer_defines.svh
// Assertion macros used by the linearizer checker.
`ifndef THERMISTOR_HUMIDITY_LINEARIZER_DEFINES_SVH
`define THERMISTOR_HUMIDITY_LINEARIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define THL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define THL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/thl_pkg.sv
// Constants, calibration tables and table lookups for the linearizer.
package thl_pkg;

  localparam int ADC_WIDTH_DEF = 12;
  localparam int TAB_W         = 12;
  localparam int RES_W         = 11;

  localparam int TP_POINTS = 83;
  localparam int HM_ROWS   = 11;
  localparam int HM_COLS   = 9;

  localparam logic [TAB_W-1:0] TP_HOT = 12'd3363;
  localparam logic signed [RES_W-1:0] TEMP_SAT = -11'sd200;
  localparam logic [6:0] HUM_CAP = 7'd98;
  localparam logic [6:0] HUM_BASE = 7'd90;

  // Row select: floor(t / 50) = (t * 41) >> 11 for 0 <= t < 500.
  localparam logic [18:0] ROW_RECIP = 19'd41;
  localparam int ROW_SHIFT = 11;
  // Blend divide: floor(x / 50) = (x * 335545) >> 24 for x < 2^18.
  localparam logic [18:0] DIV50_RECIP = 19'd335545;
  localparam int DIV50_SHIFT = 24;

  localparam logic [TAB_W-1:0] TP_TAB [0:TP_POINTS-1] = '{
    12'd3363, 12'd3329, 12'd3293, 12'd3257, 12'd3220, 12'd3182, 12'd3144, 12'd3104,
    12'd3063, 12'd3022, 12'd2980, 12'd2936, 12'd2893, 12'd2848, 12'd2803, 12'd2757,
    12'd2711, 12'd2664, 12'd2617, 12'd2569, 12'd2521, 12'd2473, 12'd2424, 12'd2376,
    12'd2327, 12'd2278, 12'd2229, 12'd2180, 12'd2131, 12'd2083, 12'd2037, 12'd1986,
    12'd1938, 12'd1891, 12'd1844, 12'd1797, 12'd1751, 12'd1706, 12'd1661, 12'd1617,
    12'd1573, 12'd1530, 12'd1487, 12'd1446, 12'd1405, 12'd1365, 12'd1326, 12'd1287,
    12'd1249, 12'd1213, 12'd1176, 12'd1141, 12'd1107, 12'd1073, 12'd1040, 12'd1008,
    12'd977,  12'd947,  12'd918,  12'd889,  12'd861,  12'd834,  12'd808,  12'd782,
    12'd757,  12'd733,  12'd710,  12'd687,  12'd665,  12'd644,  12'd621,  12'd603,
    12'd584,  12'd565,  12'd547,  12'd529,  12'd512,  12'd496,  12'd480,  12'd464,
    12'd449,  12'd435,  12'd421
  };

  localparam logic [TAB_W-1:0] HM_TAB [0:HM_ROWS*HM_COLS-1] = '{
    12'd3771, 12'd3485, 12'd2779, 12'd1753, 12'd774,  12'd262,  12'd45,  12'd8,   12'd3,
    12'd3839, 12'd3571, 12'd2952, 12'd1938, 12'd964,  12'd354,  12'd61,  12'd12,  12'd5,
    12'd3886, 12'd3653, 12'd3118, 12'd2170, 12'd1186, 12'd496,  12'd90,  12'd14,  12'd6,
    12'd3920, 12'd3726, 12'd3273, 12'd2429, 12'd1412, 12'd616,  12'd119, 12'd19,  12'd8,
    12'd3954, 12'd3793, 12'd3387, 12'd2659, 12'd1645, 12'd757,  12'd153, 12'd29,  12'd11,
    12'd3979, 12'd3843, 12'd3466, 12'd2807, 12'd1890, 12'd936,  12'd209, 12'd41,  12'd15,
    12'd3998, 12'd3886, 12'd3563, 12'd2952, 12'd1973, 12'd993,  12'd218, 12'd49,  12'd19,
    12'd4020, 12'd3918, 12'd3638, 12'd3088, 12'd2150, 12'd1107, 12'd284, 12'd63,  12'd26,
    12'd4036, 12'd3946, 12'd3716, 12'd3239, 12'd2354, 12'd1284, 12'd359, 12'd79,  12'd35,
    12'd4043, 12'd3966, 12'd3782, 12'd3360, 12'd2551, 12'd1528, 12'd433, 12'd107, 12'd47,
    12'd4050, 12'd3983, 12'd3821, 12'd3475, 12'd2740, 12'd1698, 12'd534, 12'd129, 12'd65
  };

  // Points past the end of the curve read as zero, the virtual cold-side point.
  function automatic logic [TAB_W-1:0] tp_entry(input logic [6:0] idx);
    if (idx < 7'(TP_POINTS)) begin
      return TP_TAB[idx];
    end
    return '0;
  endfunction

  function automatic logic [TAB_W-1:0] hm_entry(input logic [3:0] row, input logic [3:0] col);
    logic [6:0] idx;
    idx = ({3'b000, row} << 3) + {3'b000, row} + {3'b000, col};
    if (idx < 7'(HM_ROWS * HM_COLS)) begin
      return HM_TAB[idx];
    end
    return '0;
  endfunction

endpackage

FILE: src/thl_in_if.sv
// Sample channel: valid/ready handshake carrying one tagged converter sample.
interface thl_in_if #(
  parameter int AW = thl_pkg::ADC_WIDTH_DEF
);
  logic          valid;
  logic          ready;
  logic          req_type;
  logic [AW-1:0] adc_sample;

  modport source (output valid, output req_type, output adc_sample, input ready);
  modport sink   (input valid, input req_type, input adc_sample, output ready);
endinterface

// Result channel: valid/ready handshake carrying one linearized value.
interface thl_out_if;
  logic                            valid;
  logic                            ready;
  logic                            result_kind;
  logic signed [thl_pkg::RES_W-1:0] result_value;

  modport source (output valid, output result_kind, output result_value, input ready);
  modport sink   (input valid, input result_kind, input result_value, output ready);
endinterface

FILE: src/thl_div.sv
// Restoring divider, one quotient bit per cycle; a zero divisor gives zero.
module thl_div #(
  parameter int NW = thl_pkg::ADC_WIDTH_DEF + 4,
  parameter int DW = thl_pkg::TAB_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CW = $clog2(NW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = (den_r == '0) ? '0 : quo_r;

endmodule

FILE: src/thermistor_humidity_linearizer.sv
// Thermistor and humidity linearizer: sequencer, shared multiplier and divider.
// A temperature item, once accepted, goes through a scan of the 83-point curve at one point
// per cycle, then, unless it saturates, ADC_WIDTH + 4 divider iterations.
// A humidity item goes through a row select, then up to eleven column blends on the shared
// multiplier, each through S_HM1, S_HM2 and S_HM3, then the same divider; a stalled result holds the block.
// One item is in work at a time; synchronous active-low reset clears the stored temperature.
module thermistor_humidity_linearizer #(
  parameter int ADC_WIDTH = thl_pkg::ADC_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  thl_in_if.sink    in_ch,
  thl_out_if.source out_ch
);
  import thl_pkg::*;

  localparam int AW = ADC_WIDTH;
  localparam int NW = ADC_WIDTH + 4;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TSCAN = 4'd1;
  localparam logic [3:0] S_TDIV  = 4'd2;
  localparam logic [3:0] S_HROW  = 4'd3;
  localparam logic [3:0] S_HREM  = 4'd4;
  localparam logic [3:0] S_HM1   = 4'd5;
  localparam logic [3:0] S_HM2   = 4'd6;
  localparam logic [3:0] S_HM3   = 4'd7;
  localparam logic [3:0] S_HDIV  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [1:0] PH_C8   = 2'd0;
  localparam logic [1:0] PH_C7   = 2'd1;
  localparam logic [1:0] PH_SCAN = 2'd2;

  localparam logic [3:0] COL_LAST = 4'(HM_COLS - 1);
  localparam logic [3:0] ROW_LAST = 4'(HM_ROWS - 1);

  function automatic logic [NW-1:0] times10(input logic [AW-1:0] x);
    logic [NW-1:0] w;
    w = NW'(x);
    return (w << 3) + (w << 1);
  endfunction

  logic [3:0]             state_r, state_nxt;
  logic                   kind_r, kind_nxt;
  logic [AW-1:0]          s_r, s_nxt;
  logic [6:0]             idx_r, idx_nxt;
  logic [3:0]             row_r, row_nxt;
  logic [5:0]             brem_r, brem_nxt;
  logic [3:0]             col_r, col_nxt;
  logic [1:0]             phase_r, phase_nxt;
  logic [TAB_W-1:0]       c8_r, c8_nxt;
  logic [TAB_W-1:0]       prev_r, prev_nxt;
  logic                   below_r, below_nxt;
  logic signed [RES_W-1:0] res_r, res_nxt;
  logic signed [RES_W-1:0] last_temp_r, last_temp_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_kind_r, out_kind_nxt;
  logic signed [RES_W-1:0] out_value_r, out_value_nxt;
  logic [36:0]            mul_r;

  logic [17:0]            mul_a;
  logic [18:0]            mul_b;
  logic                   div_start;
  logic [NW-1:0]          div_num;
  logic [TAB_W-1:0]       div_den;
  logic                   div_done;
  logic [NW-1:0]          div_quot;

  logic [TAB_W-1:0]       tp_cur, tp_prev, hi, lo, cur;
  logic [3:0]             row_hi;
  logic [8:0]             row_x50;
  logic signed [RES_W-1:0] idx_s, temp_val;
  logic [6:0]             col_x10, hum_base, hum_val;
  logic [NW:0]            hum_sum;

  thl_div #(.NW(NW), .DW(TAB_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign tp_cur  = tp_entry(idx_r);
  assign tp_prev = tp_entry(idx_r - 7'd1);
  assign hi      = hm_entry(row_r, col_r);
  assign lo      = hm_entry(row_r - 4'd1, col_r);
  assign cur     = hi - mul_r[DIV50_SHIFT +: TAB_W];

  assign row_hi  = mul_r[ROW_SHIFT +: 4] + 4'd1;
  assign row_x50 = (9'(row_hi) << 5) + (9'(row_hi) << 4) + (9'(row_hi) << 1);

  // Temperature: quotient plus ten times the signed distance from the zero-degree point.
  assign idx_s    = $signed(11'(idx_r)) - 11'sd21;
  assign temp_val = (idx_s <<< 3) + (idx_s <<< 1) + $signed(11'(div_quot[3:0]));

  assign col_x10  = (7'(col_r) << 3) + (7'(col_r) << 1);
  assign hum_base = HUM_BASE - col_x10;
  assign hum_sum  = (NW+1)'(div_quot) + (NW+1)'(hum_base);

  always_comb begin
    if (below_r) begin
      hum_val = (div_quot <= NW'(10)) ? 7'(4'd10 - div_quot[3:0]) : 7'd0;
    end else begin
      hum_val = (hum_sum > (NW+1)'(HUM_CAP)) ? HUM_CAP : hum_sum[6:0];
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_kind_r;
  assign out_ch.result_value = out_value_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    s_nxt         = s_r;
    idx_nxt       = idx_r;
    row_nxt       = row_r;
    brem_nxt      = brem_r;
    col_nxt       = col_r;
    phase_nxt     = phase_r;
    c8_nxt        = c8_r;
    prev_nxt      = prev_r;
    below_nxt     = below_r;
    res_nxt       = res_r;
    last_temp_nxt = last_temp_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_num       = '0;
    div_den       = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt  = in_ch.req_type;
          s_nxt     = in_ch.adc_sample;
          idx_nxt   = 7'd1;
          state_nxt = in_ch.req_type ? S_HROW : S_TSCAN;
        end
      end
      S_TSCAN: begin
        if (idx_r != 7'(TP_POINTS) && AW'(tp_cur) >= s_r) begin
          idx_nxt = idx_r + 7'd1;
        end else if (s_r > AW'(TP_HOT)) begin
          res_nxt       = TEMP_SAT;
          last_temp_nxt = TEMP_SAT;
          state_nxt     = S_DONE;
        end else begin
          div_start = 1'b1;
          div_num   = times10(AW'(tp_prev) - s_r);
          div_den   = tp_prev - tp_cur;
          state_nxt = S_TDIV;
        end
      end
      S_TDIV: begin
        if (div_done) begin
          res_nxt       = temp_val;
          last_temp_nxt = temp_val;
          state_nxt     = S_DONE;
        end
      end
      S_HROW: begin
        mul_a     = 18'(last_temp_r[8:0]);
        mul_b     = ROW_RECIP;
        col_nxt   = COL_LAST;
        phase_nxt = PH_C8;
        // Outside the table the blend degenerates to the first or last row exactly.
        if (last_temp_r <= 11'sd0) begin
          row_nxt   = 4'd1;
          brem_nxt  = 6'd50;
          state_nxt = S_HM1;
        end else if (last_temp_r >= 11'sd500) begin
          row_nxt   = ROW_LAST;
          brem_nxt  = 6'd0;
          state_nxt = S_HM1;
        end else begin
          state_nxt = S_HREM;
        end
      end
      S_HREM: begin
        row_nxt   = row_hi;
        brem_nxt  = 6'(row_x50 - last_temp_r[8:0]);
        state_nxt = S_HM1;
      end
      S_HM1: begin
        mul_a     = 18'(hi - lo);
        mul_b     = 19'(brem_r);
        state_nxt = S_HM2;
      end
      S_HM2: begin
        mul_a     = mul_r[17:0];
        mul_b     = DIV50_RECIP;
        state_nxt = S_HM3;
      end
      S_HM3: begin
        case (phase_r)
          PH_C8: begin
            c8_nxt    = cur;
            col_nxt   = COL_LAST - 4'd1;
            phase_nxt = PH_C7;
            state_nxt = S_HM1;
          end
          PH_C7: begin
            if (s_r < AW'(c8_r)) begin
              div_start = 1'b1;
              div_num   = times10(AW'(c8_r) - s_r);
              div_den   = cur - c8_r;
              below_nxt = 1'b1;
              state_nxt = S_HDIV;
            end else begin
              col_nxt   = 4'd0;
              phase_nxt = PH_SCAN;
              state_nxt = S_HM1;
            end
          end
          default: begin
            // Walk the blended curve from the top; the sample is at or above its last point.
            if (col_r == 4'd0) begin
              prev_nxt  = cur;
              col_nxt   = 4'd1;
              state_nxt = S_HM1;
            end else if (s_r >= AW'(cur)) begin
              div_start = 1'b1;
              div_num   = times10(s_r - AW'(cur));
              div_den   = prev_r - cur;
              below_nxt = 1'b0;
              state_nxt = S_HDIV;
            end else begin
              prev_nxt  = cur;
              col_nxt   = col_r + 4'd1;
              state_nxt = S_HM1;
            end
          end
        endcase
      end
      S_HDIV: begin
        if (div_done) begin
          res_nxt   = $signed(11'(hum_val));
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_value_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_temp_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_temp_r <= last_temp_nxt;
    end
    kind_r      <= kind_nxt;
    s_r         <= s_nxt;
    idx_r       <= idx_nxt;
    row_r       <= row_nxt;
    brem_r      <= brem_nxt;
    col_r       <= col_nxt;
    phase_r     <= phase_nxt;
    c8_r        <= c8_nxt;
    prev_r      <= prev_nxt;
    below_r     <= below_nxt;
    res_r       <= res_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    mul_r       <= mul_a * mul_b;
  end

endmodule

FILE: src/thl_chk.sv
// Port-level checker for the linearizer, attached to the top level by bind.
`include "thermistor_humidity_linearizer_defines.svh"

module thl_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_result_kind,
  input logic signed [10:0] out_result_value
);

  // The block works on one item at a time, so taking an item closes the input.
  `THL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input open after accept")

  `THL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_result_value) && $stable(out_result_kind), "stalled result changed")

  `THL_ASSERT_NOW(a_hum_range, out_valid && out_result_kind, out_result_value >= 11'sd0 && out_result_value <= 11'sd98, "humidity out of range")

  `THL_ASSERT_NOW(a_temp_range, out_valid && !out_result_kind, out_result_value >= -11'sd200 && out_result_value <= 11'sd630, "temperature out of range")

endmodule

bind thermistor_humidity_linearizer thl_chk u_thl_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_kind  (out_ch.result_kind),
  .out_result_value (out_ch.result_value)
);
